// File: src/cpiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpiv_pkg
// Shared types and constants for the camera point-in-view test.
// ----------------------------------------------------------------------------
package cpiv_pkg;

	// field widths fixed by the interface
	localparam int COORD_W   = 24;
	localparam int PIX_W     = 20;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	// defaults for the top level parameters
	localparam int DEF_COORD_BITS = 24;
	localparam int DEF_COEF_BITS  = 16;

	// quotient bits kept by the divider; larger terms are clamped to QUOT_CAP
	localparam int QUOT_BITS = 22;
	localparam logic [QUOT_BITS-1:0] QUOT_CAP = QUOT_BITS'(1) << (QUOT_BITS - 1);

	// register reset values
	localparam logic [47:0] RST_ROT0   = 48'h3FFF_FFFF_C000;
	localparam logic [47:0] RST_ROT1   = 48'h0000_4000_0000;
	localparam logic [47:0] RST_ROT2   = 48'h0000_0000_4000;
	localparam logic [47:0] RST_TRANS  = 48'h0;
	localparam logic [15:0] RST_FOCAL  = 16'd6400;
	localparam logic [13:0] RST_WIDTH  = 14'd800;
	localparam logic [13:0] RST_HEIGHT = 14'd600;
	localparam logic [15:0] RST_MARGIN = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT0   = 3'd0,
		REG_ROT1   = 3'd1,
		REG_ROT2   = 3'd2,
		REG_TRANS  = 3'd3,
		REG_FOCAL  = 3'd4,
		REG_WIDTH  = 3'd5,
		REG_HEIGHT = 3'd6,
		REG_MARGIN = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} in_word_t;

	typedef struct packed {
		logic                    in_view;
		logic signed [PIX_W-1:0] pixel_u;
		logic signed [PIX_W-1:0] pixel_v;
		logic                    depth_valid;
	} out_word_t;

endpackage

// File: src/cpiv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpiv_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module cpiv_div #(
	parameter int A_W = 42,
	parameter int N_W = 58,
	parameter int QB  = cpiv_pkg::QUOT_BITS
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	input  logic [A_W-1:0] den,
	output logic [QB-1:0]  quot,
	output logic           ovf
);

	localparam int DW = N_W + QB + 1;

	logic [DW-1:0]  rem_s [QB-1];
	logic [A_W-1:0] den_s [QB-1];
	logic [QB-1:0]  quo_s [QB];
	logic           ovf_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [DW-1:0]  r_in;
		logic [DW-1:0]  sub;
		logic [A_W-1:0] d_in;
		logic [QB-1:0]  q_in;
		logic           o_in;
		logic           take;

		if (i == 0) begin : g_first
			// flag quotients that do not fit in QB bits
			assign r_in = DW'(num);
			assign d_in = den;
			assign q_in = '0;
			assign o_in = DW'(num) >= (DW'(den) << QB);
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign d_in = den_s[i-1];
			assign q_in = quo_s[i-1];
			assign o_in = ovf_s[i-1];
		end

		assign sub  = DW'(d_in) << (QB - 1 - i);
		assign take = r_in >= sub;

		// settle one quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= take ? (q_in | (QB'(1) << (QB - 1 - i))) : q_in;
				ovf_s[i] <= o_in;
			end
		end

		if (i < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= take ? (r_in - sub) : r_in;
					den_s[i] <= d_in;
				end
			end
		end
	end

	assign quot = quo_s[QB-1];
	assign ovf  = ovf_s[QB-1];

endmodule

// File: src/camera_point_in_view_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_point_in_view_test
// Rigid transform of a point into camera space, pinhole projection and
// in-view test against the image grown by a margin.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall   | cpiv_pkg::in_word_t
//  out     | output    | out_valid / out_stall | cpiv_pkg::out_word_t
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One point per cycle while the output is not stalled; the one-bit-per-stage
// divider forms f*|c|/z.
// Reset clears the valid bits and loads the register defaults.
// A stalled output word freezes the whole pipeline; in_stall rises in the same
// cycle, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module camera_point_in_view_test #(
	parameter int COORD_BITS = cpiv_pkg::DEF_COORD_BITS,
	parameter int COEF_BITS  = cpiv_pkg::DEF_COEF_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  cpiv_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output cpiv_pkg::out_word_t              out_data,
	input  logic                             cfg_we,
	input  logic [cpiv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpiv_pkg::CFG_W-1:0]       cfg_data
);

	localparam int QB      = cpiv_pkg::QUOT_BITS;
	localparam int PROD_W  = COEF_BITS + COORD_BITS;
	localparam int C_W     = PROD_W + 2;
	localparam int N_W     = C_W + 16;
	localparam int ROT_EXT = (3 * COEF_BITS > 48) ? 3 * COEF_BITS : 48;
	localparam int EXT_W   = (COORD_BITS > cpiv_pkg::COORD_W) ? COORD_BITS : cpiv_pkg::COORD_W;
	localparam int S_W     = 25;
	localparam logic signed [S_W-1:0] PIX_MAX = S_W'((1 << (cpiv_pkg::PIX_W - 1)) - 1);
	localparam logic signed [S_W-1:0] PIX_MIN = -S_W'(1 << (cpiv_pkg::PIX_W - 1));

	typedef struct packed {
		logic valid;
		logic depth_ok;
		logic neg_x;
		logic neg_y;
	} side_t;

	// configuration registers
	logic [47:0] rot_q [3];
	logic [47:0] trans_q;
	logic [15:0] focal_q;
	logic [13:0] width_q;
	logic [13:0] height_q;
	logic [15:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= cpiv_pkg::RST_ROT0;
			rot_q[1] <= cpiv_pkg::RST_ROT1;
			rot_q[2] <= cpiv_pkg::RST_ROT2;
			trans_q  <= cpiv_pkg::RST_TRANS;
			focal_q  <= cpiv_pkg::RST_FOCAL;
			width_q  <= cpiv_pkg::RST_WIDTH;
			height_q <= cpiv_pkg::RST_HEIGHT;
			margin_q <= cpiv_pkg::RST_MARGIN;
		end else if (cfg_we) begin
			case (cpiv_pkg::cfg_reg_t'(cfg_index))
				cpiv_pkg::REG_ROT0:   rot_q[0] <= cfg_data[47:0];
				cpiv_pkg::REG_ROT1:   rot_q[1] <= cfg_data[47:0];
				cpiv_pkg::REG_ROT2:   rot_q[2] <= cfg_data[47:0];
				cpiv_pkg::REG_TRANS:  trans_q  <= cfg_data[47:0];
				cpiv_pkg::REG_FOCAL:  focal_q  <= cfg_data[15:0];
				cpiv_pkg::REG_WIDTH:  width_q  <= cfg_data[13:0];
				cpiv_pkg::REG_HEIGHT: height_q <= cfg_data[13:0];
				cpiv_pkg::REG_MARGIN: margin_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// global advance: freeze everything while the output word is held
	logic        out_valid_q;
	logic        en;
	assign en       = ~(out_valid_q & out_stall);
	assign in_stall = ~en;

	// stage 1: the nine rotation products
	logic signed [COORD_BITS-1:0] pnt [3];
	logic signed [PROD_W-1:0]     prod_c [3][3];
	logic signed [PROD_W-1:0]     prod_s1 [3][3];
	logic                         v_s1;
	logic [ROT_EXT-1:0]           rot_ext [3];
	logic signed [EXT_W-1:0]      ext_x, ext_y, ext_z;

	assign ext_x  = EXT_W'(in_data.point_x);
	assign ext_y  = EXT_W'(in_data.point_y);
	assign ext_z  = EXT_W'(in_data.point_z);
	assign pnt[0] = ext_x[COORD_BITS-1:0];
	assign pnt[1] = ext_y[COORD_BITS-1:0];
	assign pnt[2] = ext_z[COORD_BITS-1:0];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rot_ext[r] = ROT_EXT'(rot_q[r]);
			for (int j = 0; j < 3; j++) begin
				prod_c[r][j] = $signed(rot_ext[r][COEF_BITS*j +: COEF_BITS]) * pnt[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
		end
	end

	// stage 2: sum the row and add the scaled translation
	logic signed [C_W-1:0] c_s2 [3];
	logic                  v_s2;
	logic signed [C_W-1:0] tt [3];
	logic signed [15:0]    tr [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tr[r] = trans_q[16*r +: 16];
			tt[r] = C_W'(tr[r]) <<< (COEF_BITS - 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				c_s2[r] <= C_W'(prod_s1[r][0]) + C_W'(prod_s1[r][1])
					+ C_W'(prod_s1[r][2]) + tt[r];
			end
		end
	end

	// stage 3: magnitudes scaled by the focal length, depth as divisor
	logic [C_W-1:0] mag_x, mag_y;
	logic [N_W-1:0] num_x_s3, num_y_s3;
	logic [C_W-1:0] den_s3;
	side_t          side_s3;

	assign mag_x = c_s2[0][C_W-1] ? C_W'(-c_s2[0]) : C_W'(c_s2[0]);
	assign mag_y = c_s2[1][C_W-1] ? C_W'(-c_s2[1]) : C_W'(c_s2[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3.valid    <= v_s2;
			side_s3.depth_ok <= c_s2[2] > 0;
			side_s3.neg_x    <= c_s2[0][C_W-1];
			side_s3.neg_y    <= c_s2[1][C_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s3 <= N_W'(focal_q) * N_W'(mag_x);
			num_y_s3 <= N_W'(focal_q) * N_W'(mag_y);
			den_s3   <= C_W'(c_s2[2]);
		end
	end

	// divider stages, sideband travels alongside
	logic [QB-1:0] quot_x, quot_y;
	logic          ovf_x, ovf_y;
	side_t         sb_s [QB];

	cpiv_div #(.A_W(C_W), .N_W(N_W), .QB(QB)) u_div_x (
		.clk  (clk),
		.en   (en),
		.num  (num_x_s3),
		.den  (den_s3),
		.quot (quot_x),
		.ovf  (ovf_x)
	);

	cpiv_div #(.A_W(C_W), .N_W(N_W), .QB(QB)) u_div_y (
		.clk  (clk),
		.en   (en),
		.num  (num_y_s3),
		.den  (den_s3),
		.quot (quot_y),
		.ovf  (ovf_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) begin
				sb_s[i] <= '0;
			end
		end else if (en) begin
			sb_s[0] <= side_s3;
			for (int i = 1; i < QB; i++) begin
				sb_s[i] <= sb_s[i-1];
			end
		end
	end

	// final stage: clamp, centre, bound test and saturate
	logic [QB-1:0]         qc_x, qc_y;
	logic signed [S_W-1:0] qx, qy, u_c, v_c, thr, h16, w16;
	logic                  in_h, in_w;
	side_t                 side_f;
	cpiv_pkg::out_word_t   word_c, out_s;

	assign side_f = sb_s[QB-1];
	assign qc_x   = (ovf_x || quot_x > cpiv_pkg::QUOT_CAP) ? cpiv_pkg::QUOT_CAP : quot_x;
	assign qc_y   = (ovf_y || quot_y > cpiv_pkg::QUOT_CAP) ? cpiv_pkg::QUOT_CAP : quot_y;
	assign qx     = S_W'(qc_x);
	assign qy     = S_W'(qc_y);
	assign thr    = S_W'($signed(margin_q));
	assign h16    = S_W'({height_q, 4'b0000});
	assign w16    = S_W'({width_q, 4'b0000});
	assign u_c    = S_W'({height_q, 3'b000}) + (side_f.neg_x ? -qx : qx);
	assign v_c    = S_W'({width_q, 3'b000}) + (side_f.neg_y ? qy : -qy);
	assign in_h   = (u_c >= -thr) && (u_c <= h16 + thr);
	assign in_w   = (v_c >= -thr) && (v_c <= w16 + thr);

	always_comb begin
		word_c = '0;
		if (side_f.depth_ok) begin
			word_c.depth_valid = 1'b1;
			word_c.in_view     = in_h & in_w;
			if (u_c > PIX_MAX) begin
				word_c.pixel_u = PIX_MAX[cpiv_pkg::PIX_W-1:0];
			end else if (u_c < PIX_MIN) begin
				word_c.pixel_u = PIX_MIN[cpiv_pkg::PIX_W-1:0];
			end else begin
				word_c.pixel_u = u_c[cpiv_pkg::PIX_W-1:0];
			end
			if (v_c > PIX_MAX) begin
				word_c.pixel_v = PIX_MAX[cpiv_pkg::PIX_W-1:0];
			end else if (v_c < PIX_MIN) begin
				word_c.pixel_v = PIX_MIN[cpiv_pkg::PIX_W-1:0];
			end else begin
				word_c.pixel_v = v_c[cpiv_pkg::PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= word_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_s;

	// a point behind the camera reports nothing but zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.depth_valid) |->
		(!out_data.in_view && out_data.pixel_u == '0 && out_data.pixel_v == '0))
	else $error("point behind camera gives non-zero result");

	// an in-view pixel never sits on a saturation rail
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.in_view) |->
		(out_data.pixel_u != PIX_MAX[cpiv_pkg::PIX_W-1:0] &&
		 out_data.pixel_u != PIX_MIN[cpiv_pkg::PIX_W-1:0] &&
		 out_data.pixel_v != PIX_MAX[cpiv_pkg::PIX_W-1:0] &&
		 out_data.pixel_v != PIX_MIN[cpiv_pkg::PIX_W-1:0]))
	else $error("in-view pixel is saturated");

	// a held output word freezes the divider sideband
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(sb_s[0]))
	else $error("pipeline moved while output was stalled");

	// a stalled input is never taken into stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(v_s1))
	else $error("first stage changed under stall");

endmodule

// File: tb/camera_point_in_view_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_point_in_view_test_test
// Drives points through the camera projection block and checks every result
// word against a local projection predictor. The run covers directed edge
// points, register extremes, random configurations under several idling
// mixes, and a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module camera_point_in_view_test_test;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 40;

	logic                                 clk;
	logic                                 arst_n    = 1'b0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	cpiv_pkg::in_word_t                   in_data   = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	cpiv_pkg::out_word_t                  out_data;
	logic                                 cfg_we    = 1'b0;
	logic [cpiv_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [cpiv_pkg::CFG_W-1:0]           cfg_data  = '0;

	// local copy of the camera registers
	logic [47:0] rot_row [3];
	logic [47:0] trans_regs;
	logic [15:0] focal;
	logic [13:0] img_width;
	logic [13:0] img_height;
	logic [15:0] margin;

	cpiv_pkg::out_word_t pending_words [$];
	int        errors;
	int        cycles;
	int        tx_idle;
	int        rx_idle;
	logic      hold_rx = 1'b0;

	camera_point_in_view_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// f*|num|/den with the fraction handled bit by bit, magnitude capped
	function automatic longint scaled_term(longint unsigned f, longint num, longint den);
		longint unsigned a, d, whole, rem, acc_q, acc_r, q;
		a = num < 0 ? longint'(-num) : longint'(num);
		d = den;
		whole = a / d;
		rem = a % d;
		acc_q = 0;
		acc_r = 0;
		if (whole > 64'd8388608)
			whole = 64'd8388608;
		for (int i = 15; i >= 0; i--) begin
			acc_r = acc_r << 1;
			acc_q = acc_q << 1;
			if (acc_r >= d) begin
				acc_r -= d;
				acc_q++;
			end
			if (f[i]) begin
				acc_r += rem;
				if (acc_r >= d) begin
					acc_r -= d;
					acc_q++;
				end
			end
		end
		q = f * whole + acc_q;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp_pixel(longint v);
		if (v > 524287)
			return 524287;
		if (v < -524288)
			return -524288;
		return v;
	endfunction

	// transform, project and bound-check one point
	function automatic cpiv_pkg::out_word_t project_point(cpiv_pkg::in_word_t pt);
		longint              p [3];
		longint              c [3];
		longint              thr, u, v;
		cpiv_pkg::out_word_t w;
		p[0] = longint'(pt.point_x);
		p[1] = longint'(pt.point_y);
		p[2] = longint'(pt.point_z);
		for (int r = 0; r < 3; r++) begin
			c[r] = longint'($signed(trans_regs[16*r +: 16])) * 16384;
			for (int j = 0; j < 3; j++)
				c[r] += longint'($signed(rot_row[r][16*j +: 16])) * p[j];
		end
		w = '0;
		w.depth_valid = c[2] > 0;
		if (w.depth_valid) begin
			thr = longint'($signed(margin));
			u = scaled_term(focal, c[0], c[2]) + longint'(img_height) * 8;
			v = -scaled_term(focal, c[1], c[2]) + longint'(img_width) * 8;
			w.in_view = (u >= -thr) && (u <= longint'(img_height) * 16 + thr) &&
			            (v >= -thr) && (v <= longint'(img_width) * 16 + thr);
			u = clamp_pixel(u);
			v = clamp_pixel(v);
			w.pixel_u = u[19:0];
			w.pixel_v = v[19:0];
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// check each accepted result word against the oldest prediction
	always @(posedge clk) begin
		cpiv_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_words.pop_front();
				if (out_data.in_view !== want.in_view)
					report_mismatch("in_view", out_data.in_view, want.in_view);
				if (out_data.pixel_u !== want.pixel_u)
					report_mismatch("pixel_u", out_data.pixel_u, want.pixel_u);
				if (out_data.pixel_v !== want.pixel_v)
					report_mismatch("pixel_v", out_data.pixel_v, want.pixel_v);
				if (out_data.depth_valid !== want.depth_valid)
					report_mismatch("depth_valid", out_data.depth_valid, want.depth_valid);
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_rx)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < rx_idle);
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL camera_point_in_view_test");
			$finish;
		end
	end

	task automatic send_point(cpiv_pkg::in_word_t pt);
		in_data  <= pt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_words.push_back(project_point(pt));
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cpiv_pkg::cfg_reg_t idx, logic [47:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			cpiv_pkg::REG_ROT0:   rot_row[0] = val;
			cpiv_pkg::REG_ROT1:   rot_row[1] = val;
			cpiv_pkg::REG_ROT2:   rot_row[2] = val;
			cpiv_pkg::REG_TRANS:  trans_regs = val;
			cpiv_pkg::REG_FOCAL:  focal      = val[15:0];
			cpiv_pkg::REG_WIDTH:  img_width  = val[13:0];
			cpiv_pkg::REG_HEIGHT: img_height = val[13:0];
			cpiv_pkg::REG_MARGIN: margin     = val[15:0];
			default: ;
		endcase
	endtask

	// camera z taken from point z, x and y straight across
	task automatic load_identity();
		write_reg(cpiv_pkg::REG_ROT0, 48'h0000_0000_4000);
		write_reg(cpiv_pkg::REG_ROT1, 48'h0000_4000_0000);
		write_reg(cpiv_pkg::REG_ROT2, 48'h4000_0000_0000);
		write_reg(cpiv_pkg::REG_TRANS, 48'h0);
	endtask

	function automatic cpiv_pkg::in_word_t make_point(int x, int y, int z);
		cpiv_pkg::in_word_t pt;
		pt.point_x = cpiv_pkg::COORD_W'(x);
		pt.point_y = cpiv_pkg::COORD_W'(y);
		pt.point_z = cpiv_pkg::COORD_W'(z);
		return pt;
	endfunction

	// mostly points in a plausible cone ahead, some anywhere
	function automatic cpiv_pkg::in_word_t random_point();
		int z, span;
		if ($urandom_range(99) < 25)
			return make_point(int'($urandom), int'($urandom), int'($urandom));
		z = $urandom_range(64, 64000);
		span = z + z / 2;
		return make_point(int'($urandom_range(0, 2 * span)) - span,
		                  int'($urandom_range(0, 2 * span)) - span, z);
	endfunction

	task automatic random_config();
		logic [47:0] r0, r1, r2;
		r0 = 48'h0000_0000_4000;
		r1 = 48'h0000_4000_0000;
		r2 = 48'h4000_0000_0000;
		if ($urandom_range(3) == 0) begin
			r0 = 48'({$urandom, $urandom});
			r1 = 48'({$urandom, $urandom});
			r2 = 48'({$urandom, $urandom});
		end else begin
			r0[15:0]  = 16'(int'($urandom_range(13000, 19000)));
			r1[31:16] = 16'(int'($urandom_range(13000, 19000)));
			r2[47:32] = 16'(int'($urandom_range(13000, 19000)));
		end
		write_reg(cpiv_pkg::REG_ROT0, r0);
		write_reg(cpiv_pkg::REG_ROT1, r1);
		write_reg(cpiv_pkg::REG_ROT2, r2);
		write_reg(cpiv_pkg::REG_TRANS, {16'(int'($urandom_range(0, 2048))),
		                                16'($urandom_range(0, 511)),
		                                16'($urandom_range(0, 511))});
		write_reg(cpiv_pkg::REG_FOCAL, 48'($urandom_range(1, 65535)));
		write_reg(cpiv_pkg::REG_WIDTH, 48'($urandom_range(1, 8192)));
		write_reg(cpiv_pkg::REG_HEIGHT, 48'($urandom_range(1, 8192)));
		write_reg(cpiv_pkg::REG_MARGIN, 48'(16'($urandom_range(0, 1600) - 400)));
	endtask

	// defaults: points on and off the camera axis, behind and at zero depth
	task automatic test_reset_defaults();
		send_point(make_point(0, 0, 0));
		send_point(make_point(2560, 0, 0));
		send_point(make_point(-2560, 0, 0));
		send_point(make_point(2560, 512, -256));
		send_point(make_point(1, 8388607, 8388607));
		send_point(make_point(1, -8388608, -8388608));
		send_point(make_point(8388607, 8388607, -8388608));
		send_point(make_point(-8388608, -8388608, 8388607));
		send_point(make_point(8388607, 0, 0));
		end_burst();
		wait_idle();
	endtask

	// register extremes with image-edge and huge-quotient points
	task automatic test_register_extremes();
		load_identity();
		write_reg(cpiv_pkg::REG_FOCAL, 48'd1);
		write_reg(cpiv_pkg::REG_WIDTH, 48'd1);
		write_reg(cpiv_pkg::REG_HEIGHT, 48'd1);
		write_reg(cpiv_pkg::REG_MARGIN, 48'h7FFF);
		send_point(make_point(0, 0, 256));
		send_point(make_point(8388607, -8388608, 1));
		send_point(make_point(-8388608, 8388607, 1));
		end_burst();
		wait_idle();
		write_reg(cpiv_pkg::REG_FOCAL, 48'd65535);
		write_reg(cpiv_pkg::REG_WIDTH, 48'd8192);
		write_reg(cpiv_pkg::REG_HEIGHT, 48'd8192);
		write_reg(cpiv_pkg::REG_MARGIN, 48'h8000);
		write_reg(cpiv_pkg::REG_TRANS, 48'h8000_7FFF_8000);
		send_point(make_point(0, 0, 8388607));
		send_point(make_point(8388607, 8388607, 8388607));
		send_point(make_point(-1, 1, 1));
		end_burst();
		wait_idle();
		// exact image edges at focal 400 px, 800 x 600
		load_identity();
		write_reg(cpiv_pkg::REG_FOCAL, 48'd6400);
		write_reg(cpiv_pkg::REG_WIDTH, 48'd800);
		write_reg(cpiv_pkg::REG_HEIGHT, 48'd600);
		write_reg(cpiv_pkg::REG_MARGIN, 48'd0);
		send_point(make_point(-192, 256, 256));
		send_point(make_point(192, -256, 256));
		send_point(make_point(193, 0, 256));
		send_point(make_point(0, 257, 256));
		send_point(make_point(0, 0, -1));
		end_burst();
		wait_idle();
	endtask

	task automatic test_random_phase(int n_items, int tx_pct, int rx_pct);
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 70 == 0) begin
				end_burst();
				wait_idle();
				random_config();
			end
			send_point(random_point());
		end
		end_burst();
		wait_idle();
	endtask

	// hold the receiver while the sender keeps offering words
	task automatic test_backpressure();
		tx_idle = 0;
		rx_idle = 0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (200) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (int i = 0; i < 80; i++)
			send_point(random_point());
		end_burst();
		wait_idle();
	endtask

	initial begin
		rot_row[0] = cpiv_pkg::RST_ROT0;
		rot_row[1] = cpiv_pkg::RST_ROT1;
		rot_row[2] = cpiv_pkg::RST_ROT2;
		trans_regs = cpiv_pkg::RST_TRANS;
		focal      = cpiv_pkg::RST_FOCAL;
		img_width  = cpiv_pkg::RST_WIDTH;
		img_height = cpiv_pkg::RST_HEIGHT;
		margin     = cpiv_pkg::RST_MARGIN;
		errors  = 0;
		cycles  = 0;
		tx_idle = 0;
		rx_idle = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_phase(250, 28, 49);
		test_random_phase(250, 49, 28);
		test_random_phase(250, 0, 0);
		test_backpressure();

		if (errors == 0)
			$display("PASS camera_point_in_view_test");
		else
			$display("FAIL camera_point_in_view_test");
		$finish;
	end

endmodule
